/* src/dpfa_pkg.sv */
// Shared types and constants for the detector packet frame assembler.
// No dependencies; imported by the decode stage and the top level.
package dpfa_pkg;

  localparam int CfgIndexW = 3;

  typedef enum logic [CfgIndexW-1:0] {
    REG_ROW_WIDTH       = 3'd0,
    REG_PACKETS_FRAME   = 3'd1,
    REG_BYTES_PACKET    = 3'd2,
    REG_BYTES_LAST      = 3'd3,
    REG_LAST_ROW        = 3'd4
  } cfg_reg_t;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_COMMIT = 1'b1;

  localparam logic [7:0]  STAT_QUADRANT_MASK = 8'b1100_0000;
  localparam logic [7:0]  STAT_LINK_MASK     = 8'b0010_0000;
  localparam logic [7:0]  STAT_CORR_MASK     = 8'b0001_1100;
  localparam logic [15:0] ISTAT_NOSTORE_MASK = 16'h8000;

  localparam logic [15:0] RESET_ROW_WIDTH     = 16'd2016;
  localparam logic [12:0] RESET_PACKETS_FRAME = 13'd672;
  localparam logic [15:0] RESET_BYTES_PACKET  = 16'd9072;
  localparam logic [15:0] RESET_BYTES_LAST    = 16'd9072;
  localparam logic [15:0] RESET_LAST_ROW      = 16'd2013;

  // Decoded packet header, held in the input register
  typedef struct packed {
    logic [31:0] fid;
    logic [31:0] row_prod;   // start_row * row_width_px
    logic [15:0] length;
    logic        is_last;
    logic [31:0] scan;
    logic [31:0] scan_clk;
    logic [31:0] sync_clk;
    logic [39:0] stamp;
    logic [23:0] exposure;
    logic [7:0]  flags;
  } hdr_t;

  typedef struct packed {
    logic [15:0] row_width;
    logic [15:0] bytes_packet;
    logic [15:0] bytes_last;
    logic [15:0] last_row;
  } dec_cfg_t;

endpackage

/* src/dpfa_header_decode.sv */
// Header decode: row offset product, write length, last-row test and flag packing.
// Depends on dpfa_pkg.
module dpfa_header_decode
  import dpfa_pkg::*;
(
  input  dec_cfg_t    cfg,
  input  logic [31:0] frame_id,
  input  logic [15:0] start_row,
  input  logic [31:0] scan_number,
  input  logic [31:0] scan_clock,
  input  logic [31:0] sync_clock,
  input  logic [63:0] image_timing_word,
  input  logic [15:0] quadrant_row_bits,
  input  logic [7:0]  status_byte,
  input  logic [15:0] image_status,
  output hdr_t        hdr
);

  logic is_last;
  logic [7:0] quad_bits;
  logic [7:0] link_bits;
  logic [7:0] corr_bits;

  assign is_last   = (start_row == cfg.last_row);
  assign quad_bits = status_byte & STAT_QUADRANT_MASK;
  assign link_bits = status_byte & STAT_LINK_MASK;
  assign corr_bits = status_byte & STAT_CORR_MASK;

  always_comb begin
    hdr.fid       = frame_id;
    hdr.row_prod  = 32'(start_row) * 32'(cfg.row_width);
    hdr.length    = is_last ? cfg.bytes_last : cfg.bytes_packet;
    hdr.is_last   = is_last;
    hdr.scan      = scan_number;
    hdr.scan_clk  = scan_clock;
    hdr.sync_clk  = sync_clock;
    hdr.stamp     = image_timing_word[39:0];
    hdr.exposure  = image_timing_word[63:40];
    hdr.flags     = {|(image_status & ISTAT_NOSTORE_MASK), corr_bits[4:2], link_bits[5],
                     quad_bits[7:6], quadrant_row_bits[0]};
  end

endmodule

/* src/detector_packet_frame_assembler_top.sv */
// Top level of the detector packet frame assembler: input register, frame state,
// result sequencing and output register. Depends on dpfa_pkg and dpfa_header_decode.
//
// One packet header enters per accepted word and yields one to three results:
// a commit of the previous frame when the frame id changes, the payload write
// command, and a commit when the start row matches last_packet_row. Results
// leave one per cycle from the output register when the output is not stalled,
// one per result a header causes; the next header is accepted in the cycle its
// final result is loaded. The offset multiply sits in front of the input
// register, in the decode stage.
module detector_packet_frame_assembler_top
  import dpfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  // packet header words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          frame_id,
  input  logic [15:0]          start_row,
  input  logic [31:0]          scan_number,
  input  logic [31:0]          scan_clock,
  input  logic [31:0]          sync_clock,
  input  logic [63:0]          image_timing_word,
  input  logic [15:0]          quadrant_row_bits,
  input  logic [7:0]           status_byte,
  input  logic [15:0]          image_status,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 result_kind,
  output logic [32:0]          byte_offset,
  output logic [15:0]          byte_length,
  output logic [31:0]          image_number,
  output logic [12:0]          missing_packets,
  output logic [31:0]          frame_scan,
  output logic [31:0]          frame_scan_time,
  output logic [31:0]          frame_sync_time,
  output logic [39:0]          frame_stamp,
  output logic [23:0]          exposure,
  output logic [7:0]           frame_flags,
  output logic                 last
);

  // configuration
  logic [15:0] row_width_px;
  logic [12:0] packets_per_frame;
  logic [15:0] packet_bytes;
  logic [15:0] bytes_last_packet;
  logic [15:0] last_packet_row;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width_px      <= RESET_ROW_WIDTH;
      packets_per_frame <= RESET_PACKETS_FRAME;
      packet_bytes      <= RESET_BYTES_PACKET;
      bytes_last_packet <= RESET_BYTES_LAST;
      last_packet_row   <= RESET_LAST_ROW;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_WIDTH:     row_width_px      <= cfg_data;
        REG_PACKETS_FRAME: packets_per_frame <= cfg_data[12:0];
        REG_BYTES_PACKET:  packet_bytes      <= cfg_data;
        REG_BYTES_LAST:    bytes_last_packet <= cfg_data;
        REG_LAST_ROW:      last_packet_row   <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode and input register
  dec_cfg_t dec_cfg;
  hdr_t     dec_hdr;
  hdr_t     hdr;
  logic     hdr_valid;

  assign dec_cfg = '{row_width: row_width_px, bytes_packet: packet_bytes,
                     bytes_last: bytes_last_packet, last_row: last_packet_row};

  dpfa_header_decode u_decode (
    .cfg               (dec_cfg),
    .frame_id          (frame_id),
    .start_row         (start_row),
    .scan_number       (scan_number),
    .scan_clock        (scan_clock),
    .sync_clock        (sync_clock),
    .image_timing_word (image_timing_word),
    .quadrant_row_bits (quadrant_row_bits),
    .status_byte       (status_byte),
    .image_status      (image_status),
    .hdr               (dec_hdr)
  );

  // frame state
  logic        frame_open;
  logic [31:0] open_frame_id;
  logic [12:0] missing_count;
  logic [31:0] held_scan;
  logic [31:0] held_scan_time;
  logic [31:0] held_sync_time;
  logic [39:0] held_stamp;
  logic [23:0] held_exposure;
  logic [7:0]  held_flags;
  logic        commit_pending;

  logic        need_flush;
  logic        emit_commit;
  logic        hdr_done;
  logic        load;
  logic        take_in;
  logic        open_new;
  logic [12:0] miss_base;
  logic [12:0] miss_dec;
  logic [33:0] offset_x3;

  assign need_flush = frame_open && (open_frame_id != hdr.fid);
  assign emit_commit = commit_pending || need_flush;
  assign load       = hdr_valid && (!out_valid || !out_stall);
  assign hdr_done   = commit_pending || (!need_flush && !hdr.is_last);
  assign in_stall   = hdr_valid && !(load && hdr_done);
  assign take_in    = in_valid && !in_stall;

  // the flush opens the new frame; a write on a closed frame opens it too
  assign open_new   = need_flush || !frame_open;
  assign miss_base  = frame_open ? missing_count : packets_per_frame;
  assign miss_dec   = (miss_base == '0) ? '0 : miss_base - 13'd1;
  assign offset_x3  = {2'b00, hdr.row_prod} + {1'b0, hdr.row_prod, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (take_in) begin
      hdr_valid <= 1'b1;
    end else if (load && hdr_done) begin
      hdr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      hdr <= dec_hdr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open     <= 1'b0;
      open_frame_id  <= '0;
      missing_count  <= '0;
      held_scan      <= '0;
      held_scan_time <= '0;
      held_sync_time <= '0;
      held_stamp     <= '0;
      held_exposure  <= '0;
      held_flags     <= '0;
      commit_pending <= 1'b0;
    end else if (load) begin
      if (commit_pending) begin
        frame_open     <= 1'b0;
        commit_pending <= 1'b0;
      end else begin
        if (open_new) begin
          frame_open     <= 1'b1;
          open_frame_id  <= hdr.fid;
          held_scan      <= hdr.scan;
          held_scan_time <= hdr.scan_clk;
          held_sync_time <= hdr.sync_clk;
          held_stamp     <= hdr.stamp;
          held_exposure  <= hdr.exposure;
          held_flags     <= hdr.flags;
        end
        if (need_flush) begin
          missing_count <= packets_per_frame;
        end else begin
          missing_count  <= miss_dec;
          commit_pending <= hdr.is_last;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last <= hdr_done;
      if (emit_commit) begin
        result_kind     <= KIND_COMMIT;
        byte_offset     <= '0;
        byte_length     <= '0;
        image_number    <= open_frame_id;
        missing_packets <= missing_count;
        frame_scan      <= held_scan;
        frame_scan_time <= held_scan_time;
        frame_sync_time <= held_sync_time;
        frame_stamp     <= held_stamp;
        exposure        <= held_exposure;
        frame_flags     <= held_flags;
      end else begin
        result_kind     <= KIND_WRITE;
        byte_offset     <= offset_x3[33:1];
        byte_length     <= hdr.length;
        image_number    <= hdr.fid;
        missing_packets <= miss_dec;
        frame_scan      <= '0;
        frame_scan_time <= '0;
        frame_sync_time <= '0;
        frame_stamp     <= '0;
        exposure        <= '0;
        frame_flags     <= '0;
      end
    end
  end

  // a pending commit always belongs to the frame the held header just wrote
  assert property (@(posedge clk) disable iff (rst)
    commit_pending |-> hdr_valid && frame_open && !need_flush)
    else $error("commit pending without a matching open frame");

  // the final commit closes the frame
  assert property (@(posedge clk) disable iff (rst)
    load && commit_pending |=> !frame_open && !commit_pending)
    else $error("frame still open after its commit");

  // a flush leaves the new frame open with the held header's id
  assert property (@(posedge clk) disable iff (rst)
    load && need_flush |=> frame_open && hdr_valid && !need_flush)
    else $error("flush did not open the new frame");

endmodule
